[rtl/spq_pkg.sv]
package spq_pkg;

	localparam int DEPTH_DEF      = 16;
	localparam int DATA_WIDTH_DEF = 32;

	localparam logic ACT_INSERT = 1'b0;
	localparam logic ACT_FETCH  = 1'b1;

	localparam logic [1:0] ST_INSERTED = 2'd0;
	localparam logic [1:0] ST_FETCHED  = 2'd1;
	localparam logic [1:0] ST_FULL     = 2'd2;
	localparam logic [1:0] ST_EMPTY    = 2'd3;

	typedef enum logic [2:0] {
		OP_IDLE,
		OP_CAPTURE,
		OP_INSERT,
		OP_FETCH,
		OP_REJECT_FULL,
		OP_REJECT_EMPTY
	} op_t;

	typedef struct packed {
		op_t op;
	} dp_cmd_t;

	typedef struct packed {
		logic action;
		logic full;
		logic empty;
	} dp_status_t;

endpackage

[rtl/spq_ctrl.sv]
module spq_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  spq_pkg::dp_status_t stat,
	output spq_pkg::dp_cmd_t    cmd
);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_EXEC = 2'b10
	} state_t;

	state_t state_q, state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		cmd.op     = spq_pkg::OP_IDLE;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.op     = spq_pkg::OP_CAPTURE;
					state_next = S_EXEC;
				end
			end
			S_EXEC: begin
				// pick the operation from the captured action and the fill level
				if (stat.action == spq_pkg::ACT_INSERT) begin
					cmd.op = stat.full ? spq_pkg::OP_REJECT_FULL : spq_pkg::OP_INSERT;
				end else begin
					cmd.op = stat.empty ? spq_pkg::OP_REJECT_EMPTY : spq_pkg::OP_FETCH;
				end
				state_next = S_IDLE;
			end
			default: begin
				state_next = S_IDLE;
			end
		endcase
	end

	assign busy = (state_q == S_EXEC);

endmodule

[rtl/spq_datapath.sv]
module spq_datapath #(
	parameter int DEPTH      = spq_pkg::DEPTH_DEF,
	parameter int DATA_WIDTH = spq_pkg::DATA_WIDTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  spq_pkg::dp_cmd_t    cmd,
	output spq_pkg::dp_status_t stat,
	input  logic                action_in,
	input  logic signed [31:0]  data_in,
	input  logic [7:0]          prio_in,
	output logic                done,
	output logic signed [31:0]  fetched_data,
	output logic [1:0]          status,
	output logic [4:0]          entry_count,
	output logic                now_empty,
	output logic                now_full
);

	localparam int CW = $clog2(DEPTH + 1);

	logic                  action_q;
	logic [DATA_WIDTH-1:0] data_q;
	logic [7:0]            prio_q;
	logic [DATA_WIDTH-1:0] slot_data_q [DEPTH];
	logic [7:0]            slot_prio_q [DEPTH];
	logic [CW-1:0]         count_q;
	logic                  done_q;
	logic signed [31:0]    fetched_q;
	logic [1:0]            status_q;

	logic [63:0]           data_wide;
	logic [63:0]           front_wide;
	logic [31:0]           count_wide;
	logic [DEPTH-1:0]      ge;

	assign data_wide  = {32'd0, data_in};
	assign front_wide = 64'(slot_data_q[0]);
	assign count_wide = 32'(count_q);

	// capture the item
	always_ff @(posedge clk) begin
		if (cmd.op == spq_pkg::OP_CAPTURE) begin
			action_q <= action_in;
			data_q   <= data_wide[DATA_WIDTH-1:0];
			prio_q   <= prio_in;
		end
	end

	// row of compare-and-shift cells; ge marks held slots that stay ahead of the new entry
	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		logic                  prev_ge;
		logic [DATA_WIDTH-1:0] left_data;
		logic [7:0]            left_prio;
		logic [DATA_WIDTH-1:0] right_data;
		logic [7:0]            right_prio;

		assign ge[g] = (CW'(g) < count_q) && (slot_prio_q[g] >= prio_q);

		if (g == 0) begin : g_first
			assign prev_ge   = 1'b1;
			assign left_data = data_q;
			assign left_prio = prio_q;
		end else begin : g_inner
			assign prev_ge   = ge[g-1];
			assign left_data = slot_data_q[g-1];
			assign left_prio = slot_prio_q[g-1];
		end

		if (g == DEPTH - 1) begin : g_last
			assign right_data = slot_data_q[g];
			assign right_prio = slot_prio_q[g];
		end else begin : g_body
			assign right_data = slot_data_q[g+1];
			assign right_prio = slot_prio_q[g+1];
		end

		always_ff @(posedge clk) begin
			case (cmd.op)
				spq_pkg::OP_INSERT: begin
					if (!ge[g]) begin
						if (prev_ge) begin
							slot_data_q[g] <= data_q;
							slot_prio_q[g] <= prio_q;
						end else begin
							slot_data_q[g] <= left_data;
							slot_prio_q[g] <= left_prio;
						end
					end
				end
				spq_pkg::OP_FETCH: begin
					slot_data_q[g] <= right_data;
					slot_prio_q[g] <= right_prio;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (cmd.op)
				spq_pkg::OP_INSERT: begin
					count_q <= count_q + 1'b1;
					done_q  <= 1'b1;
				end
				spq_pkg::OP_FETCH: begin
					count_q <= count_q - 1'b1;
					done_q  <= 1'b1;
				end
				spq_pkg::OP_REJECT_FULL, spq_pkg::OP_REJECT_EMPTY: begin
					done_q <= 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			spq_pkg::OP_INSERT: begin
				status_q  <= spq_pkg::ST_INSERTED;
				fetched_q <= '0;
			end
			spq_pkg::OP_FETCH: begin
				status_q  <= spq_pkg::ST_FETCHED;
				fetched_q <= front_wide[31:0];
			end
			spq_pkg::OP_REJECT_FULL: begin
				status_q  <= spq_pkg::ST_FULL;
				fetched_q <= '0;
			end
			spq_pkg::OP_REJECT_EMPTY: begin
				status_q  <= spq_pkg::ST_EMPTY;
				fetched_q <= '0;
			end
			default: begin
			end
		endcase
	end

	assign stat.action = action_q;
	assign stat.full   = (count_q == CW'(DEPTH));
	assign stat.empty  = (count_q == '0);

	assign done         = done_q;
	assign fetched_data = fetched_q;
	assign status       = status_q;
	assign entry_count  = count_wide[4:0];
	assign now_empty    = stat.empty;
	assign now_full     = stat.full;

`ifndef NO_ASSERTIONS
	a_no_insert_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == spq_pkg::OP_INSERT |-> !stat.full)
		else $error("insert issued to a full queue");

	a_fetch_dec: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == spq_pkg::OP_FETCH |=> count_q == CW'($past(count_q) - 1'b1))
		else $error("fetch did not drop the count by one");

	a_done_after_exec: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> ($past(cmd.op) != spq_pkg::OP_IDLE && $past(cmd.op) != spq_pkg::OP_CAPTURE))
		else $error("result strobe without an executed item");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("count beyond depth");
`endif

endmodule

[rtl/stable_priority_queue.sv]
// Each item is handled in two steps: the item is captured, then the row of compare-and-shift cells
// places or removes the entry; the result strobe follows in the next cycle.
// Start is taken only while busy is low, so a new item is accepted only once the last one has executed.
// The receiver cannot stall: done is high for exactly one cycle per item.
// arst_n clears the entry count and the controller; slot contents are not reset.
module stable_priority_queue #(
	parameter int DEPTH      = spq_pkg::DEPTH_DEF,
	parameter int DATA_WIDTH = spq_pkg::DATA_WIDTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               action,
	input  logic signed [31:0] item_data,
	input  logic [7:0]         item_priority,
	output logic               done,
	output logic signed [31:0] fetched_data,
	output logic [1:0]         status,
	output logic [4:0]         entry_count,
	output logic               now_empty,
	output logic               now_full
);

	spq_pkg::dp_cmd_t    cmd;
	spq_pkg::dp_status_t stat;

	spq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.stat   (stat),
		.cmd    (cmd)
	);

	spq_datapath #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.action_in    (action),
		.data_in      (item_data),
		.prio_in      (item_priority),
		.done         (done),
		.fetched_data (fetched_data),
		.status       (status),
		.entry_count  (entry_count),
		.now_empty    (now_empty),
		.now_full     (now_full)
	);

endmodule

[verif/stable_priority_queue_tb.sv]
`timescale 1ns / 1ps

module stable_priority_queue_tb;

	localparam int QDEPTH     = spq_pkg::DEPTH_DEF;
	localparam int STALL_LIMIT = 4000;
	localparam int MAX_REPORTS = 10;

	typedef struct {
		logic [31:0] data;
		logic [1:0]  st;
		logic [4:0]  count;
		logic        empty;
		logic        full;
	} queue_result_t;

	logic               clk           = 1'b0;
	logic               arst_n        = 1'b0;
	logic               start         = 1'b0;
	logic               action        = spq_pkg::ACT_INSERT;
	logic signed [31:0] item_data     = '0;
	logic [7:0]         item_priority = '0;
	logic               busy;
	logic               done;
	logic signed [31:0] fetched_data;
	logic [1:0]         status;
	logic [4:0]         entry_count;
	logic               now_empty;
	logic               now_full;

	// shadow copy of the sorted queue, front at index 0
	logic [31:0]   shadow_data[$];
	logic [7:0]    shadow_prio[$];
	queue_result_t pending_results[$];
	queue_result_t oldest;

	int sender_idle_pct = 0;
	int mismatches      = 0;
	int stall_cycles    = 0;
	int n_inserted      = 0;
	int n_fetched       = 0;
	int n_rej_full      = 0;
	int n_rej_empty     = 0;
	int n_checked       = 0;

	stable_priority_queue DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.action        (action),
		.item_data     (item_data),
		.item_priority (item_priority),
		.done          (done),
		.fetched_data  (fetched_data),
		.status        (status),
		.entry_count   (entry_count),
		.now_empty     (now_empty),
		.now_full      (now_full)
	);

	always #1 clk = ~clk;

	function automatic queue_result_t apply_item(logic act, logic [31:0] data, logic [7:0] prio);
		queue_result_t r;
		int pos;
		r.data = '0;
		if (act == spq_pkg::ACT_INSERT) begin
			if (shadow_data.size() >= QDEPTH) begin
				r.st = spq_pkg::ST_FULL;
				n_rej_full++;
			end else begin
				// new entry goes behind every entry of equal or higher priority
				pos = 0;
				while (pos < shadow_data.size() && shadow_prio[pos] >= prio)
					pos++;
				shadow_data.insert(pos, data);
				shadow_prio.insert(pos, prio);
				r.st = spq_pkg::ST_INSERTED;
				n_inserted++;
			end
		end else begin
			if (shadow_data.size() == 0) begin
				r.st = spq_pkg::ST_EMPTY;
				n_rej_empty++;
			end else begin
				r.data = shadow_data.pop_front();
				void'(shadow_prio.pop_front());
				r.st = spq_pkg::ST_FETCHED;
				n_fetched++;
			end
		end
		r.count = 5'(shadow_data.size());
		r.empty = (shadow_data.size() == 0);
		r.full  = (shadow_data.size() >= QDEPTH);
		return r;
	endfunction

	// called at a rising edge; returns at the edge that accepted the item
	task automatic send_item(logic act, logic [31:0] data, logic [7:0] prio);
		int gap;
		gap = 0;
		while (gap < 30 && $urandom_range(0, 99) < sender_idle_pct)
			gap++;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start         <= 1'b1;
		action        <= act;
		item_data     <= data;
		item_priority <= prio;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		pending_results.push_back(apply_item(act, data, prio));
	endtask

	// hold off until every expected result has come, plus the block's latency
	task automatic drain_results();
		start <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic test_fetch_empty();
		send_item(spq_pkg::ACT_FETCH, 32'h0, 8'h00);
		send_item(spq_pkg::ACT_FETCH, 32'hDEAD_BEEF, 8'hFF);
	endtask

	task automatic test_fill_and_overflow();
		logic [7:0]  prios[16];
		logic [31:0] words[16];
		prios = '{8'd0, 8'd255, 8'd128, 8'd255, 8'd0, 8'd128, 8'd1, 8'd254,
			8'd128, 8'd255, 8'd7, 8'd0, 8'd200, 8'd128, 8'd255, 8'd0};
		words = '{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000,
			32'h0000_0001, 32'hAAAA_AAAA, 32'h5555_5555, 32'h1234_5678,
			32'h8765_4321, 32'hFFFF_0000, 32'h0000_FFFF, 32'hC000_0003,
			32'h3000_000C, 32'h0F0F_0F0F, 32'hF0F0_F0F0, 32'h7FFF_FFFE};
		for (int i = 0; i < QDEPTH; i++)
			send_item(spq_pkg::ACT_INSERT, words[i], prios[i]);
		// inserts into a full queue are rejected, whatever the priority
		send_item(spq_pkg::ACT_INSERT, 32'h0BAD_0BAD, 8'hFF);
		send_item(spq_pkg::ACT_INSERT, 32'h8000_0000, 8'h00);
	endtask

	task automatic test_fetch_ties();
		// the equal-priority 255 entries must leave in arrival order
		repeat (4) send_item(spq_pkg::ACT_FETCH, 32'hFFFF_FFFF, 8'h00);
	endtask

	task automatic test_random(int n_items, int idle_pct);
		int insert_pct;
		int burst;
		logic [7:0] prio;
		sender_idle_pct = idle_pct;
		while (n_items > 0) begin
			// bias bursts so that the queue swings between full and empty
			case ($urandom_range(0, 2))
				0:       insert_pct = 85;
				1:       insert_pct = 50;
				default: insert_pct = 15;
			endcase
			burst = $urandom_range(10, 40);
			for (int i = 0; i < burst && n_items > 0; i++) begin
				case ($urandom_range(0, 3))
					0:       prio = 8'($urandom_range(0, 3));
					1:       prio = $urandom_range(0, 1) ? 8'hFF : 8'h00;
					default: prio = 8'($urandom_range(0, 255));
				endcase
				send_item(($urandom_range(0, 99) < insert_pct) ?
					spq_pkg::ACT_INSERT : spq_pkg::ACT_FETCH, $urandom, prio);
				n_items--;
			end
		end
		drain_results();
	endtask

	always @(posedge clk) begin
		if (arst_n && done) begin
			n_checked++;
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("ERROR: unexpected result at %0t: data=%h status=%0d count=%0d",
						$realtime, fetched_data, status, entry_count);
			end else begin
				oldest = pending_results.pop_front();
				if (fetched_data !== oldest.data || status !== oldest.st ||
						entry_count !== oldest.count || now_empty !== oldest.empty ||
						now_full !== oldest.full) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS) begin
						$display("ERROR: result %0d at %0t: expected data=%h status=%0d %s",
							n_checked, $realtime, oldest.data, oldest.st, "and");
						$display("       count=%0d empty=%b full=%b, got data=%h status=%0d",
							oldest.count, oldest.empty, oldest.full, fetched_data, status);
						$display("       count=%0d empty=%b full=%b",
							entry_count, now_empty, now_full);
					end
				end
			end
		end
	end

	// count cycles in which no item goes in and no result comes out
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("ERROR: no progress for %0d cycles", STALL_LIMIT);
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_fetch_empty();
		test_fill_and_overflow();
		test_fetch_ties();
		drain_results();

		test_random(550, 24);
		test_random(550, 45);
		test_random(550, 0);

		$display("Ran %0d items: %0d inserts, %0d fetches, %0d rejected when full,",
			n_inserted + n_fetched + n_rej_full + n_rej_empty, n_inserted, n_fetched,
			n_rej_full);
		$display("%0d fetches from empty; %0d results checked, %0d mismatches.",
			n_rej_empty, n_checked, mismatches);
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
